// ===== src/seb_pkg.sv =====
// ----------------------------------------------------------------------------
// seb_pkg
// Shared types, constants and the table builder for the soil beta block.
// ----------------------------------------------------------------------------
`default_nettype none

package seb_pkg;

    localparam int unsigned COS_TABLE_BITS_DEF = 10;

    localparam int unsigned LIQ_MUL     = 917;
    localparam int unsigned ICE_MUL     = 1000;
    localparam int unsigned WATER_DIV   = 917000;
    localparam int unsigned WATER_DIV_W = 20;
    localparam int unsigned S_W         = 43;
    localparam int unsigned NUM_W       = 63;
    localparam int unsigned T_W         = 44;
    localparam int unsigned DEN_W       = 48;
    localparam int unsigned F_W         = 16;
    localparam int unsigned ENTRY_W     = 31;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam logic [15:0] F_MIN       = 16'd655;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ONE,
        CLS_ZERO,
        CLS_SOIL
    } t_cls;

    typedef struct packed {
        logic [3:0]  land_type;
        logic        is_lake;
        logic [15:0] snow_fraction;
        logic [15:0] surface_water_fraction;
        logic [15:0] field_capacity;
        logic [31:0] liquid_mass;
        logic [31:0] ice_mass;
        logic [31:0] layer_thickness;
    } t_in_word;

    typedef struct packed {
        logic [16:0] beta;
        logic        beta_valid;
    } t_out_word;

    typedef struct packed {
        logic [15:0] fs;
        logic [15:0] fw;
        t_cls        cls;
    } t_side;

    // shift and subtract quotient, table build only
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin^4 of entry i, q1.30, taylor sum through x^19/19!
    function automatic logic [ENTRY_W-1:0] sin4_entry(input longint unsigned i,
                                                      input int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint unsigned s2;
        longint unsigned s4;
        longint unsigned dv;
        longint          acc;
        x    = (PI_HALF_Q30 * i) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 9; k++) begin
            dv   = longint'((2 * k) * (2 * k + 1));
            term = udiv64((term * x2) >> 30, dv);
            if ((k % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        s  = longint'(acc);
        s2 = (s * s) >> 30;
        s4 = (s2 * s2) >> 30;
        if (s4 > ONE_Q30) begin
            s4 = ONE_Q30;
        end
        return s4[ENTRY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/seb_cdiv.sv =====
// ----------------------------------------------------------------------------
// seb_cdiv
// Pipelined long division by the water constant, several bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module seb_cdiv import seb_pkg::*; #(
    parameter int unsigned N_W  = NUM_W,
    parameter int unsigned STEP = 7,
    parameter int unsigned SB_W = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [N_W-1:0]  i_num,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [N_W-1:0]       o_quo,
    output logic [SB_W-1:0]      o_sb
);

    localparam int unsigned STAGES = N_W / STEP;
    localparam int unsigned REM_W  = WATER_DIV_W;
    localparam logic [REM_W:0] DIV = (REM_W + 1)'(WATER_DIV);

    logic             r_valid [STAGES];
    logic [N_W-1:0]   r_num   [STAGES];
    logic [REM_W-1:0] r_rem   [STAGES];
    logic [SB_W-1:0]  r_sb    [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic             in_valid;
        logic [N_W-1:0]   in_num;
        logic [REM_W-1:0] in_rem;
        logic [SB_W-1:0]  in_sb;
        logic [N_W-1:0]   n_num;
        logic [REM_W-1:0] n_rem;

        if (g == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_num   = i_num;
            assign in_rem   = '0;
            assign in_sb    = i_sb;
        end else begin : g_next
            assign in_valid = r_valid[g-1];
            assign in_num   = r_num[g-1];
            assign in_rem   = r_rem[g-1];
            assign in_sb    = r_sb[g-1];
        end

        always_comb begin
            logic [REM_W:0] rem2;
            logic [REM_W:0] diff;
            n_num = in_num;
            n_rem = in_rem;
            for (int j = 0; j < STEP; j++) begin
                rem2  = {n_rem, n_num[N_W-1]};
                diff  = rem2 - DIV;
                n_num = {n_num[N_W-2:0], 1'b0};
                if (rem2 >= DIV) begin
                    n_rem    = diff[REM_W-1:0];
                    n_num[0] = 1'b1;
                end else begin
                    n_rem = rem2[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= in_valid;
            end
            if (i_en) begin
                r_num[g] <= n_num;
                r_rem[g] <= n_rem;
                r_sb[g]  <= in_sb;
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_quo   = r_num[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

`default_nettype wire

// ===== src/seb_vdiv.sv =====
// ----------------------------------------------------------------------------
// seb_vdiv
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module seb_vdiv import seb_pkg::*; #(
    parameter int unsigned D_W  = DEN_W,
    parameter int unsigned Q_W  = F_W,
    parameter int unsigned SB_W = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [D_W-1:0]  i_rem,
    input  wire logic [D_W-1:0]  i_den,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [Q_W-1:0]       o_quo,
    output logic [SB_W-1:0]      o_sb
);

    localparam int unsigned R_W = D_W + 1;

    logic            r_valid [Q_W];
    logic [R_W-1:0]  r_rem   [Q_W];
    logic [D_W-1:0]  r_den   [Q_W];
    logic [Q_W-1:0]  r_quo   [Q_W];
    logic [SB_W-1:0] r_sb    [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic            in_valid;
        logic [R_W-1:0]  in_rem;
        logic [D_W-1:0]  in_den;
        logic [Q_W-1:0]  in_quo;
        logic [SB_W-1:0] in_sb;
        logic [R_W-1:0]  rem2;
        logic [R_W-1:0]  den_x;
        logic [R_W-1:0]  n_rem;
        logic [Q_W-1:0]  n_quo;

        if (g == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rem   = {1'b0, i_rem};
            assign in_den   = i_den;
            assign in_quo   = '0;
            assign in_sb    = i_sb;
        end else begin : g_next
            assign in_valid = r_valid[g-1];
            assign in_rem   = r_rem[g-1];
            assign in_den   = r_den[g-1];
            assign in_quo   = r_quo[g-1];
            assign in_sb    = r_sb[g-1];
        end

        assign rem2  = {in_rem[R_W-2:0], 1'b0};
        assign den_x = {1'b0, in_den};

        always_comb begin
            if (rem2 >= den_x) begin
                n_rem = rem2 - den_x;
                n_quo = {in_quo[Q_W-2:0], 1'b1};
            end else begin
                n_rem = rem2;
                n_quo = {in_quo[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= in_valid;
            end
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= in_den;
                r_quo[g] <= n_quo;
                r_sb[g]  <= in_sb;
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

`default_nettype wire

// ===== src/seb_shape.sv =====
// ----------------------------------------------------------------------------
// seb_shape
// Table lookup with interpolation, weighting, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module seb_shape import seb_pkg::*; #(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire logic [F_W-1:0] i_f,
    input  wire logic       i_below,
    input  wire t_side      i_side,
    output logic            o_valid,
    output t_out_word       o_word
);

    localparam int unsigned IDX_W  = COS_TABLE_BITS;
    localparam int unsigned FRAC_W = F_W - COS_TABLE_BITS;
    localparam int unsigned TBL    = (1 << COS_TABLE_BITS) + 1;

    typedef logic [ENTRY_W-1:0] t_tbl [TBL];

    function automatic t_tbl build_tbl();
        t_tbl t;
        for (int i = 0; i < TBL; i++) begin
            t[i] = sin4_entry(longint'(i), COS_TABLE_BITS);
        end
        return t;
    endfunction

    localparam t_tbl SIN4 = build_tbl();

    logic [F_W-1:0]    f_cl;
    logic [IDX_W:0]    idx_a;
    logic [IDX_W:0]    idx_b;
    logic [16:0]       fsum;
    logic [16:0]       n_w;

    assign f_cl  = (i_f < F_MIN) ? F_MIN : i_f;
    assign idx_a = {1'b0, f_cl[F_W-1:FRAC_W]};
    assign idx_b = idx_a + 1'b1;
    assign fsum  = {1'b0, i_side.fs} + {1'b0, i_side.fw};
    assign n_w   = (fsum < ONE_Q16) ? (ONE_Q16 - fsum) : '0;

    // stage 1: table read
    logic               r1_valid;
    logic [ENTRY_W-1:0] r1_a;
    logic [ENTRY_W-1:0] r1_b;
    logic [FRAC_W-1:0]  r1_frac;
    logic [16:0]        r1_w;
    logic [16:0]        r1_sum;
    t_cls               r1_cls;
    logic               r1_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_a     <= SIN4[idx_a];
            r1_b     <= SIN4[idx_b];
            r1_frac  <= f_cl[FRAC_W-1:0];
            r1_w     <= n_w;
            r1_sum   <= fsum;
            r1_cls   <= i_side.cls;
            r1_below <= i_below;
        end
    end

    // stage 2: interpolation
    logic [ENTRY_W-1:0]        d;
    logic [ENTRY_W+FRAC_W-1:0] dprod;
    logic [ENTRY_W-1:0]        n_g;

    assign d     = (r1_b > r1_a) ? (r1_b - r1_a) : '0;
    assign dprod = {{FRAC_W{1'b0}}, d} * {{ENTRY_W{1'b0}}, r1_frac};
    assign n_g   = r1_a + dprod[ENTRY_W+FRAC_W-1:FRAC_W];

    logic               r2_valid;
    logic [ENTRY_W-1:0] r2_g;
    logic [16:0]        r2_w;
    logic [16:0]        r2_sum;
    t_cls               r2_cls;
    logic               r2_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_g     <= n_g;
            r2_w     <= r1_w;
            r2_sum   <= r1_sum;
            r2_cls   <= r1_cls;
            r2_below <= r1_below;
        end
    end

    // stage 3: weight
    logic [47:0] wprod;

    assign wprod = {31'd0, r2_w} * {17'd0, r2_g};

    logic        r3_valid;
    logic [16:0] r3_m;
    logic [16:0] r3_sum;
    t_cls        r3_cls;
    logic        r3_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_m     <= wprod[46:30];
            r3_sum   <= r2_sum;
            r3_cls   <= r2_cls;
            r3_below <= r2_below;
        end
    end

    // stage 4: saturate and select
    logic [17:0] bsum;
    logic [16:0] bsat;
    t_out_word   n_word;

    assign bsum = {1'b0, r3_m} + {1'b0, r3_sum};
    assign bsat = (bsum > {1'b0, ONE_Q16}) ? ONE_Q16 : bsum[16:0];

    always_comb begin
        case (r3_cls)
            CLS_SOIL: begin
                n_word.beta       = r3_below ? bsat : ONE_Q16;
                n_word.beta_valid = 1'b1;
            end
            CLS_ONE: begin
                n_word.beta       = ONE_Q16;
                n_word.beta_valid = 1'b1;
            end
            CLS_ZERO: begin
                n_word.beta       = '0;
                n_word.beta_valid = 1'b1;
            end
            default: begin
                n_word.beta       = '0;
                n_word.beta_valid = 1'b0;
            end
        endcase
    end

    logic      r_out_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r3_valid;
        end
        if (i_en) begin
            r_out <= n_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

`default_nettype wire

// ===== src/soil_evaporation_beta.sv =====
// ----------------------------------------------------------------------------
// soil_evaporation_beta
// Soil evaporation reduction factor, one ground column per word.
// ----------------------------------------------------------------------------
// Takes one column word per clock while the output is not stalled and returns
// one result word per column, in order. The path is a flat pipeline: input
// multiplies, a 9 stage divider by the water constant, a compare, a 16 stage
// divider for the water ratio, and 4 stages of table lookup and weighting.
// The sin^4 table holds 2^COS_TABLE_BITS + 1 entries built at elaboration and
// is read at two addresses per cycle. A stall at the output holds every stage.
`default_nettype none

module soil_evaporation_beta import seb_pkg::*; #(
    parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);

    localparam int unsigned SB1_W = DEN_W + $bits(t_side);
    localparam int unsigned SB2_W = 1 + $bits(t_side);

    logic en;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // input stage: class decode and products
    t_cls         n_cls;
    logic [S_W-1:0]   n_s;
    logic [DEN_W-1:0] n_den;

    always_comb begin
        n_cls = CLS_NONE;
        if (!i_in_data.is_lake) begin
            case (i_in_data.land_type) inside
                [4'd0:4'd1]: n_cls = CLS_SOIL;
                [4'd2:4'd4]: n_cls = CLS_ONE;
                [4'd5:4'd9]: n_cls = CLS_ZERO;
                default:     n_cls = CLS_NONE;
            endcase
        end
    end

    assign n_s   = ({11'd0, i_in_data.liquid_mass} * S_W'(LIQ_MUL))
                 + ({11'd0, i_in_data.ice_mass} * S_W'(ICE_MUL));
    assign n_den = {16'd0, i_in_data.field_capacity} * {16'd0, i_in_data.layer_thickness};

    logic             r_in_valid;
    logic [S_W-1:0]   r_s;
    logic [DEN_W-1:0] r_den;
    t_side            r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
        if (en) begin
            r_s         <= n_s;
            r_den       <= n_den;
            r_side.fs   <= i_in_data.snow_fraction;
            r_side.fw   <= i_in_data.surface_water_fraction;
            r_side.cls  <= n_cls;
        end
    end

    // water depth
    logic              cd_valid;
    logic [NUM_W-1:0]  cd_quo;
    logic [SB1_W-1:0]  cd_sb;

    seb_cdiv #(
        .N_W  (NUM_W),
        .STEP (7),
        .SB_W (SB1_W)
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_num   ({r_s, 20'd0}),
        .i_sb    ({r_den, r_side}),
        .o_valid (cd_valid),
        .o_quo   (cd_quo),
        .o_sb    (cd_sb)
    );

    // field capacity compare
    logic [DEN_W-1:0] t16;
    logic [DEN_W-1:0] cd_den;

    assign t16    = {cd_quo[T_W-1:0], 4'd0};
    assign cd_den = cd_sb[SB1_W-1:$bits(t_side)];

    logic             r_cmp_valid;
    logic [DEN_W-1:0] r_cmp_rem;
    logic [DEN_W-1:0] r_cmp_den;
    logic             r_cmp_below;
    t_side            r_cmp_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else if (en) begin
            r_cmp_valid <= cd_valid;
        end
        if (en) begin
            r_cmp_rem   <= t16;
            r_cmp_den   <= cd_den;
            r_cmp_below <= (t16 < cd_den);
            r_cmp_side  <= cd_sb[$bits(t_side)-1:0];
        end
    end

    // water ratio
    logic             vd_valid;
    logic [F_W-1:0]   vd_quo;
    logic [SB2_W-1:0] vd_sb;
    t_side            vd_side;

    seb_vdiv #(
        .D_W  (DEN_W),
        .Q_W  (F_W),
        .SB_W (SB2_W)
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_cmp_valid),
        .i_rem   (r_cmp_rem),
        .i_den   (r_cmp_den),
        .i_sb    ({r_cmp_below, r_cmp_side}),
        .o_valid (vd_valid),
        .o_quo   (vd_quo),
        .o_sb    (vd_sb)
    );

    assign vd_side = vd_sb[$bits(t_side)-1:0];

    seb_shape #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vd_valid),
        .i_f     (vd_quo),
        .i_below (vd_sb[SB2_W-1]),
        .i_side  (vd_side),
        .o_valid (o_out_valid),
        .o_word  (o_out_data)
    );

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.beta_valid) |-> (o_out_data.beta == '0))
        else $error("beta nonzero without beta_valid");

    a_beta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.beta <= ONE_Q16))
        else $error("beta above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmp_valid && !en) |=> r_cmp_valid)
        else $error("pipeline word lost during stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb_beta_checker.sv =====
// ----------------------------------------------------------------------------
// tb_beta_checker
// Watches both channels of the soil beta block, predicts each result word
// from the column word and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_beta_checker import seb_pkg::*; #(
    parameter int unsigned TBITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    output int        o_errors,
    output int        o_pending
);

    localparam int unsigned NENT = (1 << TBITS) + 1;
    localparam int unsigned FSH = 16 - TBITS;

    longint unsigned sin4_lut [NENT];
    t_out_word       beta_queue [$];

    function automatic longint unsigned taylor_sin(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    initial begin
        longint unsigned s;
        longint unsigned s2;
        longint unsigned s4;
        for (int i = 0; i < NENT; i++) begin
            s = taylor_sin((64'd1686629713 * longint'(i)) >> TBITS);
            s2 = (s * s) >> 30;
            s4 = (s2 * s2) >> 30;
            if (s4 > 64'd1073741824) begin
                s4 = 64'd1073741824;
            end
            sin4_lut[i] = s4;
        end
    end

    function automatic t_out_word predict_beta(input t_in_word c);
        t_out_word       r;
        longint unsigned s, t, den, f, sum, w, a, b, d, g, bt;
        int unsigned     idx, fr;
        r = '0;
        if (!c.is_lake) begin
            if (c.land_type <= 4'd1) begin
                r.beta_valid = 1'b1;
                s = longint'(c.liquid_mass) * 917 + longint'(c.ice_mass) * 1000;
                t = (s << 20) / 917000;
                den = longint'(c.field_capacity) * longint'(c.layer_thickness);
                if (t * 16 < den) begin
                    // t is below 2^44 here, so the shifted value stays in 64 bits
                    f = (t << 20) / den;
                    sum = longint'(c.snow_fraction) + longint'(c.surface_water_fraction);
                    w = (sum < 65536) ? 65536 - sum : 0;
                    if (f < 655) f = 655;
                    if (f > 65535) f = 65535;
                    idx = (f >> FSH) & ((1 << TBITS) - 1);
                    fr = f & ((1 << FSH) - 1);
                    a = sin4_lut[idx];
                    b = sin4_lut[idx + 1];
                    d = (b > a) ? b - a : 0;
                    g = a + ((d * fr) >> FSH);
                    bt = ((w * g) >> 30) + sum;
                    if (bt > 65536) bt = 65536;
                    r.beta = bt[16:0];
                end else begin
                    r.beta = ONE_Q16;
                end
            end else if (c.land_type <= 4'd4) begin
                r.beta = ONE_Q16;
                r.beta_valid = 1'b1;
            end else if (c.land_type <= 4'd9) begin
                r.beta_valid = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                beta_queue.push_back(predict_beta(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (beta_queue.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = beta_queue.pop_front();
                    if (exp_w.beta !== i_out_data.beta
                            || exp_w.beta_valid !== i_out_data.beta_valid) begin
                        $display("%0t: expected beta %0d valid %0d, got beta %0d valid %0d",
                                 $time, exp_w.beta, exp_w.beta_valid,
                                 i_out_data.beta, i_out_data.beta_valid);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= beta_queue.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random column words into the soil beta block with
// random idling on both sides and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import seb_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;
    int        errors;
    int        pending;
    bit        quiet = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    soil_evaporation_beta uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    tb_beta_checker #(.TBITS(10)) u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge clk) begin
        int stall;
        if (quiet || !rst_n) begin
            out_ready <= rst_n;
        end else if (stall > 0) begin
            stall--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_word random_column();
        t_in_word c;
        c.land_type = 4'($urandom_range(0, 3) != 0 ? $urandom_range(0, 1)
                                                   : $urandom_range(0, 15));
        c.is_lake = ($urandom_range(0, 9) == 0);
        c.snow_fraction = 16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 8000));
        c.surface_water_fraction =
            16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 8000));
        c.field_capacity = 16'($urandom_range(1, 65535));
        c.layer_thickness = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0400_0000);
        if ($urandom_range(0, 3) == 0) begin
            c.liquid_mass = $urandom;
            c.ice_mass = $urandom;
        end else begin
            // keep water depth near field capacity so f spans the table
            c.liquid_mass = $urandom_range(0, 32'h00ff_ffff) >> $urandom_range(0, 16);
            c.ice_mass = $urandom_range(0, 32'h00ff_ffff) >> $urandom_range(0, 16);
        end
        return c;
    endfunction

    task automatic send_column(input t_in_word c);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        t_in_word c;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++) begin
            c = random_column();
            c.land_type = 4'(i);
            c.is_lake = 1'b0;
            send_column(c);
        end
        c = '0; c.field_capacity = 16'd1; c.layer_thickness = 32'd1;
        send_column(c);
        c = '1; c.is_lake = 1'b1;
        send_column(c);
        c = '1; c.land_type = 4'd0; c.is_lake = 1'b0;
        send_column(c);
        c = '0; c.field_capacity = 16'hffff; c.layer_thickness = 32'hffff_ffff;
        c.liquid_mass = 32'd1;
        send_column(c);
        c.land_type = 4'd1; c.snow_fraction = 16'hffff; c.surface_water_fraction = 16'hffff;
        send_column(c);
        c = '0; c.field_capacity = 16'd32768; c.layer_thickness = 32'h0100_0000;
        c.liquid_mass = 32'h00c8_0000;
        send_column(c);
        wait_drained();

        for (int i = 0; i < 900; i++) begin
            if (i == 400) wait_drained();
            if (i == 780) quiet = 1'b1;
            send_column(random_column());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
